FILE: rtl/ffba_pkg.sv
// Package for the first-fit block allocator: status codes, request kinds,
// config indices, the size limit and sequencer states. No dependencies.
`default_nettype none
package ffba_pkg;
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_LARGE     = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_FULL      = 3'd4,
    ST_BADFREE   = 3'd5
  } status_t;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [3:0] CFG_HEAP_BASE = 4'd0;
  localparam logic [3:0] CFG_HEAP_END  = 4'd1;

  localparam logic [26:0] SIZE_LIMIT = 27'h2000000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_SPLIT,
    S_APPEND,
    S_LINK,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/ffba_table.sv
// Block table memory for the first-fit allocator: one synchronous RAM,
// one write and one registered read port. Does not use ffba_pkg.
`default_nettype none
module ffba_table #(
  parameter int AW = 6,
  parameter int DW = 66
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/first_fit_block_allocator.sv
// First-fit block allocator top level: request sequencer around the block table.
// Depends on ffba_pkg and ffba_table.
`default_nettype none
// One request is processed at a time. The sequencer walks the address-ordered
// block list through the table RAM (registered read), visiting each entry with
// an address step, then a compare step. A zero, oversized or null request goes
// straight to the result; otherwise the walk ends in a hit (split when the block
// is large enough), in a failed free, or in an append, which also links the old
// tail unless it creates the very first block; a failed append gives an error
// status. A walk visits at most MAX_BLOCKS entries. A finished result moves into
// an output register; while it waits for out_tready the next request is already
// accepted and walked, and it holds in its last step until the register frees.
// Adjacent free blocks are never merged. No clearing pass is needed after
// reset: entries beyond the fill count are never read.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16,
  parameter int ALIGN_BYTES  = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,  // req_size[25:0], free_address[57:26], zero fill
  input  wire logic        in_tuser,  // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata, // payload_address[31:0], status[34:32], zero fill
  input  wire logic        cfg_we,
  input  wire logic  [3:0] cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  localparam int AW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int LW = CW;
  localparam int DW = 32 + 26 + 1 + LW;
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
  localparam logic [LW-1:0] NO_LINK = LW'(MAX_BLOCKS);
  localparam logic [33:0] HDR = 34'(HEADER_BYTES);
  localparam logic [27:0] ALM = 28'(ALIGN_BYTES - 1);

  logic [31:0] heap_base_r, heap_end_r, heap_top_r, heap_top_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  state_t state_r, state_nxt;
  logic kind_r, kind_nxt;
  logic [26:0] size_r, size_nxt;
  logic [31:0] faddr_r, faddr_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [31:0] oaddr_r, oaddr_nxt;
  status_t ostat_r, ostat_nxt;
  logic ovalid_r, ovalid_nxt;
  logic [31:0] res_addr_r, res_addr_nxt;
  status_t res_stat_r, res_stat_nxt;
  logic [DW-1:0] ent_r, ent_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  logic [31:0] e_start;
  logic [25:0] e_bytes;
  logic e_free;
  logic [LW-1:0] e_link;
  assign {e_start, e_bytes, e_free, e_link} = rdata;

  ffba_table #(.AW(AW), .DW(DW)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [27:0] rounded;
  logic [33:0] top_need;
  logic [31:0] top_eff;
  always_comb begin
    rounded = (28'(in_tdata[25:0]) + ALM) / 28'(ALIGN_BYTES) * 28'(ALIGN_BYTES);
    top_eff = (used_r == '0) ? heap_base_r : heap_top_r;
    top_need = 34'(top_eff) + 34'(size_r) + HDR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= '0;
      heap_end_r  <= '1;
      heap_top_r  <= '0;
      used_r      <= '0;
      tail_r      <= '0;
      state_r     <= S_IDLE;
      ovalid_r    <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_HEAP_BASE) heap_base_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_HEAP_END)  heap_end_r  <= cfg_wdata;
      heap_top_r <= heap_top_nxt;
      used_r     <= used_nxt;
      tail_r     <= tail_nxt;
      state_r    <= state_nxt;
      ovalid_r   <= ovalid_nxt;
    end
    kind_r     <= kind_nxt;
    size_r     <= size_nxt;
    faddr_r    <= faddr_nxt;
    cur_r      <= cur_nxt;
    steps_r    <= steps_nxt;
    oaddr_r    <= oaddr_nxt;
    ostat_r    <= ostat_nxt;
    res_addr_r <= res_addr_nxt;
    res_stat_r <= res_stat_nxt;
    ent_r      <= ent_nxt;
  end

  // output register parts the sides: a waiting result does not block input
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, 3'(res_stat_r), res_addr_r};

  always_comb begin
    state_nxt = state_r; heap_top_nxt = heap_top_r; used_nxt = used_r; tail_nxt = tail_r;
    kind_nxt = kind_r; size_nxt = size_r; faddr_nxt = faddr_r; cur_nxt = cur_r;
    steps_nxt = steps_r; oaddr_nxt = oaddr_r; ostat_nxt = ostat_r; ent_nxt = ent_r;
    res_addr_nxt = res_addr_r; res_stat_nxt = res_stat_r;
    ovalid_nxt = ovalid_r && !out_tready;
    we = 1'b0; waddr = '0; wdata = '0; raddr = cur_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          kind_nxt = in_tuser;
          size_nxt = rounded[26:0];
          faddr_nxt = in_tdata[57:26];
          cur_nxt = '0;
          steps_nxt = '0;
          oaddr_nxt = '0;
          ostat_nxt = ST_OK;
          if (in_tuser == KIND_FREE) begin
            state_nxt = (in_tdata[57:26] == '0) ? S_DONE : S_READ;
          end else if (in_tdata[25:0] == '0) begin
            ostat_nxt = ST_ZERO; state_nxt = S_DONE;
          end else if (rounded > 28'(SIZE_LIMIT)) begin
            ostat_nxt = ST_LARGE; state_nxt = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (CW'(cur_r) >= used_r || steps_r >= MAXC) begin
          state_nxt = (kind_r == KIND_FREE) ? S_DONE : S_APPEND;
          if (kind_r == KIND_FREE) ostat_nxt = ST_BADFREE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        ent_nxt = rdata;
        steps_nxt = steps_r + 1'b1;
        cur_nxt = e_link;
        state_nxt = S_READ;
        if (kind_r == KIND_FREE) begin
          if (34'(e_start) + HDR == 34'(faddr_r)) begin
            we = 1'b1; waddr = cur_r[AW-1:0];
            wdata = {e_start, e_bytes, 1'b1, e_link};
            state_nxt = S_DONE;
          end
        end else if (e_free && 27'(e_bytes) >= size_r) begin
          oaddr_nxt = 32'(34'(e_start) + HDR);
          cur_nxt = cur_r;
          if (27'(e_bytes) > 27'(28'(size_r) + 28'(HEADER_BYTES)) && used_r < MAXC
              && 28'(e_bytes) > 28'(size_r) + 28'(HEADER_BYTES)) begin
            we = 1'b1; waddr = cur_r[AW-1:0];
            wdata = {e_start, size_r[25:0], 1'b0, LW'(used_r)};
            state_nxt = S_SPLIT;
          end else begin
            we = 1'b1; waddr = cur_r[AW-1:0];
            wdata = {e_start, e_bytes, 1'b0, e_link};
            state_nxt = S_DONE;
          end
        end
      end
      S_SPLIT: begin
        we = 1'b1; waddr = used_r[AW-1:0];
        wdata = {32'(34'(ent_r[DW-1 -: 32]) + HDR + 34'(size_r)),
                 26'(ent_r[LW+26 -: 26] - size_r[25:0] - 26'(HEADER_BYTES)),
                 1'b1, ent_r[LW-1:0]};
        if (tail_r == cur_r[AW-1:0]) tail_nxt = used_r[AW-1:0];
        used_nxt = used_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_APPEND: begin
        if (used_r >= MAXC) begin
          ostat_nxt = ST_FULL; state_nxt = S_DONE;
        end else begin
          if (used_r == '0) heap_top_nxt = heap_base_r;
          if (top_need > 34'(heap_end_r)) begin
            ostat_nxt = ST_EXHAUSTED; state_nxt = S_DONE;
          end else begin
            we = 1'b1; waddr = used_r[AW-1:0];
            wdata = {top_eff, size_r[25:0], 1'b0, NO_LINK};
            oaddr_nxt = 32'(34'(top_eff) + HDR);
            heap_top_nxt = top_need[31:0];
            state_nxt = (used_r == '0) ? S_DONE : S_LINK;
            if (used_r == '0) begin
              tail_nxt = '0; used_nxt = used_r + 1'b1;
            end
          end
        end
      end
      S_LINK: begin
        // read tail entry first: its link field is then rewritten from rdata
        raddr = tail_r;
        state_nxt = S_IDLE;
        if (steps_r != '1) begin
          steps_nxt = '1;
          state_nxt = S_LINK;
        end else begin
          we = 1'b1; waddr = tail_r;
          wdata = {rdata[DW-1:LW], LW'(used_r)};
          tail_nxt = used_r[AW-1:0];
          used_nxt = used_r + 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold here until the output register is free
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          res_addr_nxt = oaddr_r;
          res_stat_nxt = ostat_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire
